@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ess_pkg.sv @@
// ----------------------------------------------------------------------------
// ess_pkg
// Operation codes, register indexes and reset values of the sweep sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ess_pkg;

   // request operations
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_STEP    = 2'd2;
   localparam logic [1:0] OP_IGNORE  = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_SPIN_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PAUSE_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPIN_SPEED   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPAN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SCAN     = 3'd5;

   // reset values
   localparam logic [15:0] RST_SPIN_PERIOD  = 16'd200;
   localparam logic [15:0] RST_PAUSE_PERIOD = 16'd100;
   localparam logic [14:0] RST_SPIN_SPEED   = 15'd300;
   localparam logic [7:0]  RST_MAX_SPAN     = 8'd4;
   localparam logic [31:0] RST_TIMEOUT      = 32'd5000;
   localparam logic [31:0] RST_MIN_SCAN     = 32'd200;

   // search state
   typedef struct packed {
      logic [31:0] search_start;
      logic [31:0] elapsed;
      logic [31:0] phase_start;
      logic        spinning;
      logic        turn_negative;
      logic [7:0]  span_length;
      logic [7:0]  spins_done;
   } search_state_type;

   function automatic search_state_type cleared_state(input logic [31:0] t);
      search_state_type s;
      s.search_start  = t;
      s.elapsed       = '0;
      s.phase_start   = t;
      s.spinning      = 1'b1;
      s.turn_negative = 1'b0;
      s.span_length   = 8'd1;
      s.spins_done    = 8'd0;
      return s;
   endfunction

endpackage

`default_nettype wire

@@ src/expanding_sweep_search_sequencer.sv @@
// ----------------------------------------------------------------------------
// expanding_sweep_search_sequencer
// Line-recovery sweep: alternating spin and pause with a growing span.
// ----------------------------------------------------------------------------
// One request is taken every cycle and its response appears in the next cycle
// in the response register. The whole step (elapsed time, phase compare, span
// counting) is worked out in one pass between the request handshake and that
// register, so throughput is one request per clock; a stalled response holds
// the register and pushes stall back onto the request side. Config must be
// written on the csr_ port while no request is in flight; nothing enforces it.
`default_nettype none

module expanding_sweep_search_sequencer
   import ess_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_op,
   input  wire logic [31:0]            req_now,
   input  wire logic                   req_line_seen,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [15:0]          rsp_left_cmd,
   output logic signed [15:0]          rsp_right_cmd,
   output logic                        rsp_moving,
   output logic [31:0]                 rsp_elapsed_ms,
   output logic                        rsp_timed_out,
   output logic                        rsp_line_found,
   // configuration
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [15:0] spin_period_ff;
   logic [15:0] pause_period_ff;
   logic [14:0] spin_speed_ff;
   logic [7:0]  max_span_ff;
   logic [31:0] timeout_ff;
   logic [31:0] min_scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_period_ff  <= RST_SPIN_PERIOD;
         pause_period_ff <= RST_PAUSE_PERIOD;
         spin_speed_ff   <= RST_SPIN_SPEED;
         max_span_ff     <= RST_MAX_SPAN;
         timeout_ff      <= RST_TIMEOUT;
         min_scan_ff     <= RST_MIN_SCAN;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SPIN_PERIOD:  spin_period_ff  <= csr_wdata[15:0];
            REG_PAUSE_PERIOD: pause_period_ff <= csr_wdata[15:0];
            REG_SPIN_SPEED:   spin_speed_ff   <= csr_wdata[14:0];
            REG_MAX_SPAN:     max_span_ff     <= csr_wdata[7:0];
            REG_TIMEOUT:      timeout_ff      <= csr_wdata;
            REG_MIN_SCAN:     min_scan_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   logic rsp_valid_ff;
   logic req_accept;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // step logic
   search_state_type state_ff;
   search_state_type state_in;
   logic [15:0] left_in;
   logic        moving_in;
   logic [31:0] phase_base;
   logic        spin_now;
   logic [31:0] phase_time;
   logic [7:0]  spins_inc;
   logic [15:0] speed_ext;

   assign phase_base = (state_ff.phase_start == '0) ? req_now : state_ff.phase_start;
   assign spin_now   = (state_ff.phase_start == '0) ? 1'b1 : state_ff.spinning;
   assign phase_time = req_now - phase_base;
   assign spins_inc  = (state_ff.spins_done < state_ff.span_length) ?
                       state_ff.spins_done + 8'd1 : state_ff.spins_done;
   assign speed_ext  = {1'b0, spin_speed_ff};

   always_comb begin
      state_in  = state_ff;
      left_in   = '0;
      moving_in = 1'b0;
      unique case (req_op)
         OP_CLEAR:   state_in = cleared_state('0);
         OP_RESTART: state_in = cleared_state(req_now);
         OP_STEP: begin
            state_in.elapsed     = (state_ff.search_start == '0) ? '0 :
                                   req_now - state_ff.search_start;
            state_in.phase_start = phase_base;
            state_in.spinning    = spin_now;
            if (spin_now) begin
               if (phase_time >= {16'd0, spin_period_ff}) begin
                  // spin period over: pause and count it towards the span
                  state_in.spinning    = 1'b0;
                  state_in.phase_start = req_now;
                  state_in.spins_done  = spins_inc;
                  if (spins_inc >= state_ff.span_length) begin
                     state_in.spins_done    = 8'd0;
                     state_in.turn_negative = ~state_ff.turn_negative;
                     if (state_ff.span_length < max_span_ff)
                        state_in.span_length = state_ff.span_length + 8'd1;
                  end
               end else begin
                  moving_in = 1'b1;
                  left_in   = state_ff.turn_negative ? 16'd0 - speed_ext : speed_ext;
               end
            end else if (phase_time >= {16'd0, pause_period_ff}) begin
               state_in.spinning    = 1'b1;
               state_in.phase_start = req_now;
            end
         end
         OP_IGNORE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cleared_state('0);
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic [15:0] left_ff;
   logic        moving_ff;
   logic [31:0] elapsed_ff;
   logic        timed_out_ff;
   logic        line_found_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_ff       <= left_in;
         moving_ff     <= moving_in;
         elapsed_ff    <= state_in.elapsed;
         timed_out_ff  <= state_in.elapsed >= timeout_ff;
         line_found_ff <= req_line_seen & (state_in.elapsed >= min_scan_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_cmd   = left_ff;
   assign rsp_right_cmd  = 16'd0 - left_ff;
   assign rsp_moving     = moving_ff;
   assign rsp_elapsed_ms = elapsed_ff;
   assign rsp_timed_out  = timed_out_ff;
   assign rsp_line_found = line_found_ff;

   // checks
`include "assert_macros.svh"

   `ASSERT_CLK(a_span_order, clock, reset,
      state_ff.spins_done < state_ff.span_length, "spin count reached span length")
   `ASSERT_CLK(a_speed_mirror, clock, reset,
      !rsp_valid || (rsp_left_cmd + rsp_right_cmd) == 16'sd0, "wheel speeds not opposite")
   `ASSERT_CLK(a_still_zero, clock, reset,
      !rsp_valid || rsp_moving || rsp_left_cmd == 16'sd0, "speed while standing still")
   `ASSERT_NEXT(a_clear_idle, clock, reset, req_accept && req_op == OP_CLEAR,
      state_ff.search_start == '0 && rsp_elapsed_ms == '0 && !rsp_moving, "clear not idle")

endmodule

`default_nettype wire
